// ===== rtl/core/ssm_pkg.sv =====
package ssm_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W = 2;
   localparam int DEPTH_DEFAULT = 32;

   localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
   localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic append_a;
      logic append_b;
      logic step;
      logic emit_empty;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic both_empty;
      logic step_last;
      logic slot_free;
   } sts_type;

endpackage

// ===== rtl/core/ssm_req_if.sv =====
interface ssm_req_if;
   logic                                valid;
   logic                                ready;
   logic [ssm_pkg::OP_W-1:0]            op;
   logic signed [ssm_pkg::DATA_W-1:0]   value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== rtl/core/ssm_rsp_if.sv =====
interface ssm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ssm_pkg::DATA_W-1:0]   value_res;
   logic                                last;
   logic                                empty_res;
   logic                                overflow;

   modport source (output valid, output value_res, output last, output empty_res,
                   output overflow, input ready);
   modport sink   (input valid, input value_res, input last, input empty_res,
                   input overflow, output ready);
endinterface

// ===== rtl/core/ssm_ctrl.sv =====
module ssm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [ssm_pkg::OP_W-1:0]  req_op,
   output logic                      req_ready,
   input  ssm_pkg::sts_type          sts,
   output ssm_pkg::cmd_type          cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_EMPTY
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  ssm_pkg::OP_APPEND_A: cmd.append_a = 1'b1;
                  ssm_pkg::OP_APPEND_B: cmd.append_b = 1'b1;
                  ssm_pkg::OP_MERGE: begin
                     state_in = sts.both_empty ? ST_EMPTY : ST_MERGE;
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            if (sts.slot_free) begin
               cmd.step = 1'b1;
               if (sts.step_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (sts.slot_free) begin
               cmd.emit_empty = 1'b1;
               cmd.finish     = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/ssm_dp.sv =====
module ssm_dp #(
   parameter int DEPTH = ssm_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ssm_pkg::cmd_type                  cmd,
   output ssm_pkg::sts_type                  sts,
   input  logic signed [ssm_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic signed [ssm_pkg::DATA_W-1:0] rsp_value_res,
   output logic                              rsp_last,
   output logic                              rsp_empty_res,
   output logic                              rsp_overflow
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   logic signed [ssm_pkg::DATA_W-1:0] mem_a [DEPTH];
   logic signed [ssm_pkg::DATA_W-1:0] mem_b [DEPTH];

   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] ia_ff, ia_in;
   logic [CW-1:0] ib_ff, ib_in;
   logic          dropped_ff, dropped_in;

   logic signed [ssm_pkg::DATA_W-1:0] head_a_ff;
   logic signed [ssm_pkg::DATA_W-1:0] head_b_ff;

   logic                              out_valid_ff, out_valid_in;
   logic signed [ssm_pkg::DATA_W-1:0] out_value_ff;
   logic                              out_last_ff;
   logic                              out_empty_ff;
   logic                              out_overflow_ff;

   logic          a_left, b_left, take_a;
   logic [CW-1:0] ia_next, ib_next;
   logic          load_out;
   logic          step_last;

   assign a_left  = (ia_ff < count_a_ff);
   assign b_left  = (ib_ff < count_b_ff);
   // ties go to a, keeping the merge stable
   assign take_a  = a_left && (!b_left || (head_a_ff <= head_b_ff));
   assign ia_next = CW'(ia_ff + 1'b1);
   assign ib_next = CW'(ib_ff + 1'b1);
   assign step_last = take_a ? ((ia_next == count_a_ff) && (ib_ff == count_b_ff))
                             : ((ia_ff == count_a_ff) && (ib_next == count_b_ff));

   assign load_out = cmd.step || cmd.emit_empty;

   assign sts.both_empty = (count_a_ff == '0) && (count_b_ff == '0);
   assign sts.step_last  = step_last;
   assign sts.slot_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      dropped_in = dropped_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      if (cmd.append_a) begin
         if (count_a_ff == FULL) dropped_in = 1'b1;
         else count_a_in = CW'(count_a_ff + 1'b1);
      end
      if (cmd.append_b) begin
         if (count_b_ff == FULL) dropped_in = 1'b1;
         else count_b_in = CW'(count_b_ff + 1'b1);
      end
      if (cmd.step) begin
         if (take_a) ia_in = ia_next;
         else ib_in = ib_next;
      end
      if (cmd.finish) begin
         count_a_in = '0;
         count_b_in = '0;
         dropped_in = 1'b0;
         ia_in      = '0;
         ib_in      = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (load_out) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         dropped_ff   <= 1'b0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         dropped_ff   <= dropped_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // buffer writes and registered head reads, one port each way
   always_ff @(posedge clock) begin
      if (cmd.append_a && (count_a_ff != FULL)) begin
         mem_a[count_a_ff[IW-1:0]] <= req_value;
      end
      if (cmd.append_b && (count_b_ff != FULL)) begin
         mem_b[count_b_ff[IW-1:0]] <= req_value;
      end
      head_a_ff <= mem_a[ia_in[IW-1:0]];
      head_b_ff <= mem_b[ib_in[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_value_ff    <= cmd.emit_empty ? '0 : (take_a ? head_a_ff : head_b_ff);
         out_last_ff     <= cmd.emit_empty ? 1'b1 : step_last;
         out_empty_ff    <= cmd.emit_empty;
         out_overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_res = out_value_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_empty_res = out_empty_ff;
   assign rsp_overflow  = out_overflow_ff;

endmodule

// ===== rtl/core/sorted_sequence_merge.sv =====
// stable merge of two ascending sequences of signed 32-bit words
// req channel: op 0 appends value to buffer a, op 1 to buffer b, op 2 merges;
//   op 3 is ignored. each buffer holds DEPTH words, a full buffer drops the
//   append and sets a sticky overflow flag
// rsp channel: one word per merged value, smallest first, a before b on ties;
//   last marks the final word, overflow reports the sticky flag. a merge of
//   two empty buffers gives a single word with empty_res and last set
// appends give no word. a merge of n values holds req ready low until its last
//   word is loaded; the first word is presented once the controller has entered
//   its merge state and the output register has loaded, then one per cycle while
//   the receiver takes them, paced by the registered read port of each buffer
// when the receiver stalls the merge waits on the output register, and
//   req is taken again as soon as the last word sits in that register
// reset empties both buffers and clears the overflow flag and the output
//   valid flag; buffer contents are not cleared
module sorted_sequence_merge #(
   parameter int DEPTH = ssm_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ssm_req_if.sink    req_bus,
   ssm_rsp_if.source  rsp_bus
);

   ssm_pkg::cmd_type cmd;
   ssm_pkg::sts_type sts;

   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssm_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_value     (req_bus.value),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_value_res (rsp_bus.value_res),
      .rsp_last      (rsp_bus.last),
      .rsp_empty_res (rsp_bus.empty_res),
      .rsp_overflow  (rsp_bus.overflow)
   );

endmodule

// ===== tb/sorted_sequence_merge_tb.sv =====
`timescale 1ns / 100ps

module sorted_sequence_merge_tb;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 9;
   localparam int ITEM_TARGET    = 115;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;

   // op code that the block ignores
   localparam logic [ssm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [ssm_pkg::DATA_W-1:0] value_res;
      logic                              last;
      logic                              empty_res;
      logic                              overflow;
   } merge_word_type;

   class sorted_merge_board_type;
      int                                depth;
      logic signed [ssm_pkg::DATA_W-1:0] buf_a[$];
      logic signed [ssm_pkg::DATA_W-1:0] buf_b[$];
      bit                                dropped;
      merge_word_type                    words_due[$];
      int                                errors;
      int                                words_checked;
      int                                merges;
      int                                empty_merges;
      int                                overflow_merges;

      function new(int depth_i);
         depth = depth_i;
      endfunction

      // update the buffers for one accepted request word, queue merged words
      function void take_request(logic [ssm_pkg::OP_W-1:0] op,
                                 logic signed [ssm_pkg::DATA_W-1:0] value);
         int             ia;
         int             ib;
         int             total;
         merge_word_type w;
         case (op)
            ssm_pkg::OP_APPEND_A: begin
               if (buf_a.size() < depth) buf_a.push_back(value);
               else dropped = 1'b1;
            end
            ssm_pkg::OP_APPEND_B: begin
               if (buf_b.size() < depth) buf_b.push_back(value);
               else dropped = 1'b1;
            end
            ssm_pkg::OP_MERGE: begin
               total = buf_a.size() + buf_b.size();
               merges++;
               if (dropped) overflow_merges++;
               if (total == 0) begin
                  w.value_res = '0;
                  w.last      = 1'b1;
                  w.empty_res = 1'b1;
                  w.overflow  = dropped;
                  words_due.push_back(w);
                  empty_merges++;
               end else begin
                  ia = 0;
                  ib = 0;
                  for (int n = 0; n < total; n++) begin
                     // ties go to buffer a
                     if (ia < buf_a.size() &&
                         (ib >= buf_b.size() || buf_a[ia] <= buf_b[ib])) begin
                        w.value_res = buf_a[ia];
                        ia++;
                     end else begin
                        w.value_res = buf_b[ib];
                        ib++;
                     end
                     w.last      = (n == total - 1);
                     w.empty_res = 1'b0;
                     w.overflow  = dropped;
                     words_due.push_back(w);
                  end
               end
               buf_a.delete();
               buf_b.delete();
               dropped = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void check_word(merge_word_type got);
         merge_word_type want;
         if (words_due.size() == 0) begin
            errors++;
            $display("%0t tb: unexpected word value %0d last %b empty %b overflow %b",
                     $time, got.value_res, got.last, got.empty_res, got.overflow);
            return;
         end
         want = words_due.pop_front();
         words_checked++;
         if (got !== want) begin
            errors++;
            $display("%0t tb: mismatch expected value %0d last %b empty %b overflow %b,",
                     $time, want.value_res, want.last, want.empty_res, want.overflow);
            $display("%0t tb:          actual value %0d last %b empty %b overflow %b",
                     $time, got.value_res, got.last, got.empty_res, got.overflow);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssm_req_if req_if_i ();
   ssm_rsp_if rsp_if_i ();

   sorted_sequence_merge #(
      .DEPTH(ssm_pkg::DEPTH_DEFAULT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if_i),
      .rsp_bus(rsp_if_i)
   );

   sorted_merge_board_type board;
   merge_word_type         rsp_seen;
   int                     stall_pct  = 0;
   int                     max_gap    = 0;
   int                     burst_left = 0;
   int                     items_sent = 0;
   int                     idle_cycles = 0;

   always #(CLK_HALF) clock = ~clock;

   // receiver stalls at a rate set per phase
   always @(posedge clock) begin
      if (reset) rsp_if_i.ready <= 1'b0;
      else rsp_if_i.ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if_i.valid && rsp_if_i.ready) begin
         rsp_seen.value_res = rsp_if_i.value_res;
         rsp_seen.last      = rsp_if_i.last;
         rsp_seen.empty_res = rsp_if_i.empty_res;
         rsp_seen.overflow  = rsp_if_i.overflow;
         board.check_word(rsp_seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if_i.valid && req_if_i.ready) ||
          (rsp_if_i.valid && rsp_if_i.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t tb: watchdog expired, no word moved for %0d cycles",
                     $time, idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // sender works in bursts with random gaps between them
   task automatic send_word(input logic [ssm_pkg::OP_W-1:0] op,
                            input logic signed [ssm_pkg::DATA_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
         if (gap > 0) begin
            req_if_i.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if_i.valid <= 1'b1;
      req_if_i.op    <= op;
      req_if_i.value <= value;
      @(posedge clock);
      while (!req_if_i.ready) @(posedge clock);
      board.take_request(op, value);
      items_sent++;
   endtask

   function automatic int pick_value(int mode);
      case (mode)
         0: return $urandom;
         1: return int'($urandom_range(20, 0)) - 10;
         default: begin
            case ($urandom_range(4, 0))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return -1;
               3: return 0;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // one group of appends and a merge; kinds cover sorted, unsorted, overfull, empty and noise
   task automatic run_random_group(input bit force_overfill);
      int  kind;
      int  mode;
      int  na;
      int  nb;
      int  qa[$];
      int  qb[$];
      bit  to_a;
      kind = force_overfill ? 0 : $urandom_range(99, 0);
      mode = $urandom_range(2, 0);
      case ($urandom_range(4, 0))
         0, 1: begin stall_pct = 0;  max_gap = 0; end
         2: begin stall_pct = 25; max_gap = 3; end
         3: begin stall_pct = 50; max_gap = 8; end
         default: begin stall_pct = 80; max_gap = 2; end
      endcase
      if (kind < 8) begin
         // fill one buffer past its depth, the other possibly to the brim
         na = ssm_pkg::DEPTH_DEFAULT + $urandom_range(3, 1);
         nb = ($urandom_range(1, 0) == 1) ? ssm_pkg::DEPTH_DEFAULT : $urandom_range(4, 0);
         if ($urandom_range(1, 0) == 1) begin
            int t;
            t = na;
            na = nb;
            nb = t;
         end
      end else if (kind < 22) begin
         na = $urandom_range(6, 0);
         nb = $urandom_range(6, 0);
      end else if (kind < 30) begin
         na = 0;
         nb = 0;
      end else begin
         na = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(8, 1);
         nb = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(8, 1);
      end
      for (int i = 0; i < na; i++) qa.push_back(pick_value(mode));
      for (int i = 0; i < nb; i++) qb.push_back(pick_value(mode));
      // unsorted groups keep their random order
      if (kind < 8 || kind >= 22) begin
         qa.sort();
         qb.sort();
      end
      if (kind >= 22 && kind < 30) begin
         repeat ($urandom_range(3, 1)) send_word(OP_UNUSED, pick_value(0));
      end
      while (qa.size() != 0 || qb.size() != 0) begin
         to_a = (qb.size() == 0) || (qa.size() != 0 && $urandom_range(1, 0) == 1);
         if (to_a) send_word(ssm_pkg::OP_APPEND_A, qa.pop_front());
         else send_word(ssm_pkg::OP_APPEND_B, qb.pop_front());
         if ($urandom_range(24, 0) == 0) send_word(OP_UNUSED, pick_value(0));
      end
      send_word(ssm_pkg::OP_MERGE, pick_value(0));
   endtask

   initial begin
      board = new(ssm_pkg::DEPTH_DEFAULT);
      req_if_i.valid = 1'b0;
      req_if_i.op    = ssm_pkg::OP_APPEND_A;
      req_if_i.value = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty merge, extremes, ties, ignored op, unsorted, one side empty
      send_word(ssm_pkg::OP_MERGE, 32'sh7fff_ffff);
      send_word(ssm_pkg::OP_APPEND_A, 32'sh8000_0000);
      send_word(ssm_pkg::OP_APPEND_A, -32'sd1);
      send_word(ssm_pkg::OP_APPEND_B, 32'sh8000_0000);
      send_word(ssm_pkg::OP_APPEND_A, 32'sd0);
      send_word(ssm_pkg::OP_APPEND_B, 32'sd0);
      send_word(ssm_pkg::OP_APPEND_B, 32'sd0);
      send_word(ssm_pkg::OP_APPEND_A, 32'sh7fff_ffff);
      send_word(ssm_pkg::OP_APPEND_B, 32'sh7fff_ffff);
      send_word(OP_UNUSED, -32'sd1);
      send_word(ssm_pkg::OP_MERGE, 32'sd0);
      stall_pct = 40;
      max_gap   = 4;
      send_word(OP_UNUSED, 32'sh8000_0000);
      send_word(ssm_pkg::OP_APPEND_A, 32'sd7);
      send_word(ssm_pkg::OP_APPEND_A, 32'sd2);
      send_word(ssm_pkg::OP_APPEND_B, 32'sd5);
      send_word(ssm_pkg::OP_MERGE, -32'sd1);
      send_word(ssm_pkg::OP_APPEND_B, -32'sd3);
      send_word(ssm_pkg::OP_APPEND_B, 32'sd9);
      send_word(ssm_pkg::OP_MERGE, 32'sd0);
      send_word(ssm_pkg::OP_APPEND_A, 32'sd1);
      send_word(ssm_pkg::OP_MERGE, 32'sd0);

      run_random_group(1'b1);
      while (items_sent < ITEM_TARGET) run_random_group(1'b0);
      req_if_i.valid <= 1'b0;
      stall_pct = 20;

      while (board.words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d request words, %0d merges (%0d of empty buffers, %0d after a drop)",
               items_sent, board.merges, board.empty_merges, board.overflow_merges);
      $display("tb: %0d merged words checked, %0d errors", board.words_checked, board.errors);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
